// ===== design/sta_pkg.sv =====
// ----------------------------------------------------------------------------
// sta_pkg: shared types and constants
// Beat formats for the two-port stability pipeline, fixed-point widths and
// the word that travels from the front-end multiplier stages to the back end.
// ----------------------------------------------------------------------------
package sta_pkg;

  localparam int IN_FRAC_BITS  = 14;
  localparam int OUT_FRAC_BITS = 16;

  // S-parameter products carry 2*IN_FRAC_BITS fraction bits
  localparam int DET_W  = 34;                   // exact determinant
  localparam int WR_W   = DET_W - IN_FRAC_BITS;  // determinant cut to F bits
  localparam int NORM_W = 63;                   // |S12*S21|^2
  localparam int ACC_W  = 39;                   // k numerator, circle denominator
  localparam int CN_W   = 36;                   // circle centre numerators

  localparam int ISQ_STAGES = 32;               // one root bit per stage
  localparam int ISQ_W      = 64;

  localparam int DIV_NW = 54;                   // dividend
  localparam int DIV_DW = 39;                   // divisor
  localparam int DIV_QW = 32;                   // quotient bits, one per stage
  localparam int DIV_CW = DIV_DW + DIV_QW;      // compare width

  typedef struct packed {
    logic signed [15:0] s11_re;
    logic signed [15:0] s11_im;
    logic signed [15:0] s12_re;
    logic signed [15:0] s12_im;
    logic signed [15:0] s21_re;
    logic signed [15:0] s21_im;
    logic signed [15:0] s22_re;
    logic signed [15:0] s22_im;
    logic               port_select;
  } in_t;

  typedef struct packed {
    logic signed [31:0] det_re;
    logic signed [31:0] det_im;
    logic        [30:0] k_factor;
    logic signed [31:0] circle_center_re;
    logic signed [31:0] circle_center_im;
    logic        [30:0] circle_radius;
    logic               k_undefined;
    logic               circle_undefined;
  } out_t;

  // front-end result handed to the root and divider stages
  typedef struct packed {
    logic                     valid;
    logic signed [31:0]       det_re;
    logic signed [31:0]       det_im;
    logic                     kund;
    logic [NORM_W-1:0]        normp;
    logic signed [ACC_W-1:0]  num;
    logic signed [ACC_W-1:0]  cden;
    logic signed [CN_W-1:0]   numr;
    logic signed [CN_W-1:0]   numi;
  } front_t;

endpackage

// ===== design/sta_front.sv =====
// ----------------------------------------------------------------------------
// sta_front: product and sum stages
// Four register stages: raw products, determinant, squared terms, then the
// k numerator, circle denominator and centre numerators.
// ----------------------------------------------------------------------------
module sta_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  sta_pkg::in_t     in_item,
  output sta_pkg::front_t  front
);

  localparam logic signed [34:0] ONE_2F = 35'sd1 <<< (2 * sta_pkg::IN_FRAC_BITS);

  // stage 1: products
  logic               s1_valid_r;
  logic signed [31:0] s1_brcr_r, s1_bici_r, s1_brci_r, s1_bicr_r;
  logic signed [31:0] s1_ardr_r, s1_aidi_r, s1_ardi_r, s1_aidr_r;
  logic signed [31:0] s1_arar_r, s1_aiai_r, s1_drdr_r, s1_didi_r;
  logic               s1_sel_r;
  logic signed [15:0] s1_spr_r, s1_spi_r, s1_sqr_r, s1_sqi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_brcr_r <= in_item.s12_re * in_item.s21_re;
      s1_bici_r <= in_item.s12_im * in_item.s21_im;
      s1_brci_r <= in_item.s12_re * in_item.s21_im;
      s1_bicr_r <= in_item.s12_im * in_item.s21_re;
      s1_ardr_r <= in_item.s11_re * in_item.s22_re;
      s1_aidi_r <= in_item.s11_im * in_item.s22_im;
      s1_ardi_r <= in_item.s11_re * in_item.s22_im;
      s1_aidr_r <= in_item.s11_im * in_item.s22_re;
      s1_arar_r <= in_item.s11_re * in_item.s11_re;
      s1_aiai_r <= in_item.s11_im * in_item.s11_im;
      s1_drdr_r <= in_item.s22_re * in_item.s22_re;
      s1_didi_r <= in_item.s22_im * in_item.s22_im;
      s1_sel_r  <= in_item.port_select;
      s1_spr_r  <= in_item.port_select ? in_item.s22_re : in_item.s11_re;
      s1_spi_r  <= in_item.port_select ? in_item.s22_im : in_item.s11_im;
      s1_sqr_r  <= in_item.port_select ? in_item.s11_re : in_item.s22_re;
      s1_sqi_r  <= in_item.port_select ? in_item.s11_im : in_item.s22_im;
    end
  end

  // stage 2: S12*S21, determinant, port norms
  logic signed [32:0]                   pr_c, pi_c;
  logic signed [sta_pkg::DET_W-1:0]     detr_c, deti_c;

  assign pr_c   = 33'(s1_brcr_r) - 33'(s1_bici_r);
  assign pi_c   = 33'(s1_brci_r) + 33'(s1_bicr_r);
  assign detr_c = sta_pkg::DET_W'(s1_ardr_r) - sta_pkg::DET_W'(s1_aidi_r)
                - sta_pkg::DET_W'(pr_c);
  assign deti_c = sta_pkg::DET_W'(s1_ardi_r) + sta_pkg::DET_W'(s1_aidr_r)
                - sta_pkg::DET_W'(pi_c);

  logic                              s2_valid_r;
  logic signed [32:0]                s2_pr_r, s2_pi_r;
  logic signed [sta_pkg::DET_W-1:0]  s2_detr_r, s2_deti_r;
  logic signed [sta_pkg::WR_W-1:0]   s2_wr_r, s2_wi_r;
  logic [31:0]                       s2_n11_r, s2_n22_r;
  logic                              s2_sel_r;
  logic signed [15:0]                s2_spr_r, s2_spi_r, s2_sqr_r, s2_sqi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pr_r   <= pr_c;
      s2_pi_r   <= pi_c;
      s2_detr_r <= detr_c;
      s2_deti_r <= deti_c;
      // drop the low fraction bits: floor toward minus infinity
      s2_wr_r   <= detr_c[sta_pkg::DET_W-1:sta_pkg::IN_FRAC_BITS];
      s2_wi_r   <= deti_c[sta_pkg::DET_W-1:sta_pkg::IN_FRAC_BITS];
      s2_n11_r  <= 32'(s1_arar_r) + 32'(s1_aiai_r);
      s2_n22_r  <= 32'(s1_drdr_r) + 32'(s1_didi_r);
      s2_sel_r  <= s1_sel_r;
      s2_spr_r  <= s1_spr_r;
      s2_spi_r  <= s1_spi_r;
      s2_sqr_r  <= s1_sqr_r;
      s2_sqi_r  <= s1_sqi_r;
    end
  end

  // stage 3: squares and det*conj(Sqq) partial products
  logic signed [32:0] pra_c, pia_c;
  logic [31:0]        prm_c, pim_c;
  logic [63:0]        pr2_c, pi2_c;
  logic signed [39:0] wr2_c, wi2_c;

  assign pra_c = s2_pr_r[32] ? -s2_pr_r : s2_pr_r;
  assign pia_c = s2_pi_r[32] ? -s2_pi_r : s2_pi_r;
  assign prm_c = pra_c[31:0];
  assign pim_c = pia_c[31:0];
  assign pr2_c = 64'(prm_c) * 64'(prm_c);
  assign pi2_c = 64'(pim_c) * 64'(pim_c);
  assign wr2_c = 40'(s2_wr_r) * 40'(s2_wr_r);
  assign wi2_c = 40'(s2_wi_r) * 40'(s2_wi_r);

  logic                               s3_valid_r;
  logic signed [31:0]                 s3_detre_r, s3_detim_r;
  logic                               s3_kund_r;
  logic [sta_pkg::NORM_W-1:0]         s3_pr2_r, s3_pi2_r;
  logic [36:0]                        s3_wr2_r, s3_wi2_r;
  logic signed [sta_pkg::CN_W-1:0]    s3_qa_r, s3_qb_r, s3_qc_r, s3_qd_r;
  logic signed [34:0]                 s3_nbase_r;
  logic [31:0]                        s3_spn_r;
  logic signed [15:0]                 s3_spr_r, s3_spi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_detre_r <= 32'(s2_detr_r >>> (2 * sta_pkg::IN_FRAC_BITS - sta_pkg::OUT_FRAC_BITS));
      s3_detim_r <= 32'(s2_deti_r >>> (2 * sta_pkg::IN_FRAC_BITS - sta_pkg::OUT_FRAC_BITS));
      s3_kund_r  <= (s2_pr_r == '0) && (s2_pi_r == '0);
      s3_pr2_r   <= pr2_c[sta_pkg::NORM_W-1:0];
      s3_pi2_r   <= pi2_c[sta_pkg::NORM_W-1:0];
      s3_wr2_r   <= wr2_c[36:0];
      s3_wi2_r   <= wi2_c[36:0];
      s3_qa_r    <= sta_pkg::CN_W'(s2_wr_r) * sta_pkg::CN_W'(s2_sqr_r);
      s3_qb_r    <= sta_pkg::CN_W'(s2_wi_r) * sta_pkg::CN_W'(s2_sqi_r);
      s3_qc_r    <= sta_pkg::CN_W'(s2_wi_r) * sta_pkg::CN_W'(s2_sqr_r);
      s3_qd_r    <= sta_pkg::CN_W'(s2_wr_r) * sta_pkg::CN_W'(s2_sqi_r);
      s3_nbase_r <= ONE_2F - signed'(35'(s2_n11_r)) - signed'(35'(s2_n22_r));
      s3_spn_r   <= s2_sel_r ? s2_n22_r : s2_n11_r;
      s3_spr_r   <= s2_spr_r;
      s3_spi_r   <= s2_spi_r;
    end
  end

  // stage 4: sums
  logic [37:0]                      nd_c;
  logic signed [sta_pkg::CN_W-1:0]  qr_c, qi_c;

  assign nd_c = 38'(s3_wr2_r) + 38'(s3_wi2_r);
  assign qr_c = s3_qa_r + s3_qb_r;
  assign qi_c = s3_qc_r - s3_qd_r;

  sta_pkg::front_t front_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else if (en) begin
      front_r.valid <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_r.det_re <= s3_detre_r;
      front_r.det_im <= s3_detim_r;
      front_r.kund   <= s3_kund_r;
      front_r.normp  <= s3_pr2_r + s3_pi2_r;
      front_r.num    <= sta_pkg::ACC_W'(s3_nbase_r) + signed'(sta_pkg::ACC_W'(nd_c));
      front_r.cden   <= signed'(sta_pkg::ACC_W'(s3_spn_r)) - signed'(sta_pkg::ACC_W'(nd_c));
      front_r.numr   <= (sta_pkg::CN_W'(s3_spr_r) <<< sta_pkg::IN_FRAC_BITS) - qr_c;
      front_r.numi   <= (sta_pkg::CN_W'(s3_spi_r) <<< sta_pkg::IN_FRAC_BITS) - qi_c;
    end
  end

  assign front = front_r;

endmodule

// ===== design/sta_isqrt.sv =====
// ----------------------------------------------------------------------------
// sta_isqrt: pipelined integer square root
// Floor of the square root of a 63-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module sta_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [sta_pkg::NORM_W-1:0]  radicand,
  output logic [31:0]                 root
);

  logic [sta_pkg::ISQ_W-1:0] x_r [sta_pkg::ISQ_STAGES];
  logic [sta_pkg::ISQ_W-1:0] r_r [sta_pkg::ISQ_STAGES];

  for (genvar i = 0; i < sta_pkg::ISQ_STAGES; i++) begin : g_st
    logic [sta_pkg::ISQ_W-1:0] x_in, r_in, bit_c, trial_c;
    logic                      take_c;

    if (i == 0) begin : g_first
      assign x_in = sta_pkg::ISQ_W'(radicand);
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign r_in = r_r[i-1];
    end

    assign bit_c   = sta_pkg::ISQ_W'(1) << (2 * (sta_pkg::ISQ_STAGES - 1 - i));
    assign trial_c = r_in + bit_c;
    assign take_c  = x_in >= trial_c;

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= take_c ? x_in - trial_c : x_in;
        r_r[i] <= take_c ? (r_in >> 1) + bit_c : r_in >> 1;
      end
    end
  end

  assign root = r_r[sta_pkg::ISQ_STAGES-1][31:0];

endmodule

// ===== design/sta_div.sv =====
// ----------------------------------------------------------------------------
// sta_div: pipelined restoring divider
// Unsigned quotient, one bit per stage; ovf flags a quotient that needs more
// than DIV_QW bits.
// ----------------------------------------------------------------------------
module sta_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [sta_pkg::DIV_NW-1:0]  dividend,
  input  logic [sta_pkg::DIV_DW-1:0]  divisor,
  output logic [sta_pkg::DIV_QW-1:0]  quotient,
  output logic                        ovf
);

  logic [sta_pkg::DIV_NW-1:0] rem_r [sta_pkg::DIV_QW];
  logic [sta_pkg::DIV_QW-1:0] q_r   [sta_pkg::DIV_QW];
  logic [sta_pkg::DIV_DW-1:0] den_r [sta_pkg::DIV_QW];
  logic                       ovf_r [sta_pkg::DIV_QW];

  for (genvar j = 0; j < sta_pkg::DIV_QW; j++) begin : g_st
    logic [sta_pkg::DIV_NW-1:0] rem_in;
    logic [sta_pkg::DIV_QW-1:0] q_in;
    logic [sta_pkg::DIV_DW-1:0] den_in;
    logic                       ovf_in;
    logic [sta_pkg::DIV_CW-1:0] dsh_c;
    logic                       take_c;

    if (j == 0) begin : g_first
      assign rem_in = dividend;
      assign q_in   = '0;
      assign den_in = divisor;
      assign ovf_in = sta_pkg::DIV_CW'(dividend)
                      >= (sta_pkg::DIV_CW'(divisor) << sta_pkg::DIV_QW);
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign den_in = den_r[j-1];
      assign ovf_in = ovf_r[j-1];
    end

    assign dsh_c  = sta_pkg::DIV_CW'(den_in) << (sta_pkg::DIV_QW - 1 - j);
    assign take_c = sta_pkg::DIV_CW'(rem_in) >= dsh_c;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= take_c ? rem_in - sta_pkg::DIV_NW'(dsh_c) : rem_in;
        q_r[j]   <= q_in | (sta_pkg::DIV_QW'(take_c) << (sta_pkg::DIV_QW - 1 - j));
        den_r[j] <= den_in;
        ovf_r[j] <= ovf_in;
      end
    end
  end

  assign quotient = q_r[sta_pkg::DIV_QW-1];
  assign ovf      = ovf_r[sta_pkg::DIV_QW-1];

endmodule

// ===== design/twoport_stability_analysis.sv =====
// ----------------------------------------------------------------------------
// twoport_stability_analysis: Rollett k and stability circle
// Determinant, stability factor and selected-port stability circle of one
// S-parameter point per beat.
//
//   channel | direction | ports                          | beat
//   in      | input     | in_valid, in_stall, in_item    | S11..S22, port select
//   out     | output    | out_valid, out_stall, out_item | det, k, circle, flags
//
// One beat enters per clock while in_stall is low; the path holds 4
// product/sum stages, 32 square-root stages (one root bit each), 32 divider
// stages (one quotient bit each) and the output register.
// Synchronous active-low reset clears the valid bits only.
// The whole pipeline holds while a result sits in the output register and
// out_stall is high; in_stall follows that hold.
// ----------------------------------------------------------------------------
module twoport_stability_analysis (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sta_pkg::in_t   in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output sta_pkg::out_t  out_item
);

  typedef struct packed {
    logic                             valid;
    logic signed [31:0]               det_re;
    logic signed [31:0]               det_im;
    logic                             kund;
    logic                             cund;
    logic                             num_pos;
    logic [37:0]                      k_mag;
    logic                             cre_neg;
    logic                             cim_neg;
    logic [sta_pkg::CN_W-1:0]         cnr_mag;
    logic [sta_pkg::CN_W-1:0]         cni_mag;
    logic [sta_pkg::DIV_DW-1:0]       cden_mag;
  } side_a_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] det_re;
    logic signed [31:0] det_im;
    logic               kund;
    logic               cund;
    logic               num_pos;
    logic               cre_neg;
    logic               cim_neg;
  } side_b_t;

  function automatic logic [30:0] usat31(logic [sta_pkg::DIV_QW-1:0] q, logic o);
    return (o || q[31]) ? 31'h7FFF_FFFF : q[30:0];
  endfunction

  function automatic logic [31:0] ssat32(logic [sta_pkg::DIV_QW-1:0] q, logic o, logic neg);
    logic [31:0] mag;
    if (neg) begin
      mag = (o || q > 32'h8000_0000) ? 32'h8000_0000 : q;
      return -mag;
    end
    return {1'b0, usat31(q, o)};
  endfunction

  logic en;
  logic out_valid_r;
  sta_pkg::out_t out_item_r;

  // advance unless a finished beat is held at the output
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  sta_pkg::front_t front;

  sta_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_item  (in_item),
    .front    (front)
  );

  logic [31:0] root;

  sta_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (front.normp),
    .root     (root)
  );

  // sideband entering the root stages
  side_a_t a_nxt;
  logic signed [sta_pkg::CN_W-1:0]  nri_c;
  logic signed [sta_pkg::ACC_W-1:0] cdabs_c;

  assign nri_c   = front.numi[sta_pkg::CN_W-1] ? -front.numi : front.numi;
  assign cdabs_c = front.cden[sta_pkg::ACC_W-1] ? -front.cden : front.cden;

  always_comb begin
    a_nxt.valid    = front.valid;
    a_nxt.det_re   = front.det_re;
    a_nxt.det_im   = front.det_im;
    a_nxt.kund     = front.kund;
    a_nxt.cund     = front.cden == '0;
    a_nxt.num_pos  = !front.num[sta_pkg::ACC_W-1] && (front.num != '0);
    a_nxt.k_mag    = a_nxt.num_pos ? front.num[37:0] : '0;
    a_nxt.cre_neg  = front.numr[sta_pkg::CN_W-1] != front.cden[sta_pkg::ACC_W-1];
    // centre imaginary part divides the negated numerator
    a_nxt.cim_neg  = (!front.numi[sta_pkg::CN_W-1] && (front.numi != '0))
                     != front.cden[sta_pkg::ACC_W-1];
    a_nxt.cnr_mag  = front.numr[sta_pkg::CN_W-1] ? -front.numr : front.numr;
    a_nxt.cni_mag  = nri_c;
    a_nxt.cden_mag = cdabs_c;
  end

  side_a_t a_line_r [sta_pkg::ISQ_STAGES];

  for (genvar i = 0; i < sta_pkg::ISQ_STAGES; i++) begin : g_a
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_line_r[i].valid <= 1'b0;
      end else if (en) begin
        a_line_r[i].valid <= (i == 0) ? a_nxt.valid : a_line_r[(i == 0) ? 0 : i-1].valid;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (i == 0) begin
          a_line_r[i].det_re   <= a_nxt.det_re;
          a_line_r[i].det_im   <= a_nxt.det_im;
          a_line_r[i].kund     <= a_nxt.kund;
          a_line_r[i].cund     <= a_nxt.cund;
          a_line_r[i].num_pos  <= a_nxt.num_pos;
          a_line_r[i].k_mag    <= a_nxt.k_mag;
          a_line_r[i].cre_neg  <= a_nxt.cre_neg;
          a_line_r[i].cim_neg  <= a_nxt.cim_neg;
          a_line_r[i].cnr_mag  <= a_nxt.cnr_mag;
          a_line_r[i].cni_mag  <= a_nxt.cni_mag;
          a_line_r[i].cden_mag <= a_nxt.cden_mag;
        end else begin
          a_line_r[i].det_re   <= a_line_r[(i == 0) ? 0 : i-1].det_re;
          a_line_r[i].det_im   <= a_line_r[(i == 0) ? 0 : i-1].det_im;
          a_line_r[i].kund     <= a_line_r[(i == 0) ? 0 : i-1].kund;
          a_line_r[i].cund     <= a_line_r[(i == 0) ? 0 : i-1].cund;
          a_line_r[i].num_pos  <= a_line_r[(i == 0) ? 0 : i-1].num_pos;
          a_line_r[i].k_mag    <= a_line_r[(i == 0) ? 0 : i-1].k_mag;
          a_line_r[i].cre_neg  <= a_line_r[(i == 0) ? 0 : i-1].cre_neg;
          a_line_r[i].cim_neg  <= a_line_r[(i == 0) ? 0 : i-1].cim_neg;
          a_line_r[i].cnr_mag  <= a_line_r[(i == 0) ? 0 : i-1].cnr_mag;
          a_line_r[i].cni_mag  <= a_line_r[(i == 0) ? 0 : i-1].cni_mag;
          a_line_r[i].cden_mag <= a_line_r[(i == 0) ? 0 : i-1].cden_mag;
        end
      end
    end
  end

  side_a_t a_end;
  assign a_end = a_line_r[sta_pkg::ISQ_STAGES-1];

  // dividers: k, centre re, centre im, radius
  logic [sta_pkg::DIV_QW-1:0] k_q, cr_q, ci_q, rd_q;
  logic                       k_o, cr_o, ci_o, rd_o;

  sta_div u_div_k (
    .clk      (clk),
    .en       (en),
    .dividend (sta_pkg::DIV_NW'({a_end.k_mag, sta_pkg::OUT_FRAC_BITS'(0)})),
    .divisor  (sta_pkg::DIV_DW'({root, 1'b0})),
    .quotient (k_q),
    .ovf      (k_o)
  );

  sta_div u_div_cr (
    .clk      (clk),
    .en       (en),
    .dividend (sta_pkg::DIV_NW'({a_end.cnr_mag, sta_pkg::OUT_FRAC_BITS'(0)})),
    .divisor  (a_end.cden_mag),
    .quotient (cr_q),
    .ovf      (cr_o)
  );

  sta_div u_div_ci (
    .clk      (clk),
    .en       (en),
    .dividend (sta_pkg::DIV_NW'({a_end.cni_mag, sta_pkg::OUT_FRAC_BITS'(0)})),
    .divisor  (a_end.cden_mag),
    .quotient (ci_q),
    .ovf      (ci_o)
  );

  sta_div u_div_rd (
    .clk      (clk),
    .en       (en),
    .dividend (sta_pkg::DIV_NW'({root, sta_pkg::OUT_FRAC_BITS'(0)})),
    .divisor  (a_end.cden_mag),
    .quotient (rd_q),
    .ovf      (rd_o)
  );

  side_b_t b_nxt;
  always_comb begin
    b_nxt.valid   = a_end.valid;
    b_nxt.det_re  = a_end.det_re;
    b_nxt.det_im  = a_end.det_im;
    b_nxt.kund    = a_end.kund;
    b_nxt.cund    = a_end.cund;
    b_nxt.num_pos = a_end.num_pos;
    b_nxt.cre_neg = a_end.cre_neg;
    b_nxt.cim_neg = a_end.cim_neg;
  end

  side_b_t b_line_r [sta_pkg::DIV_QW];

  for (genvar j = 0; j < sta_pkg::DIV_QW; j++) begin : g_b
    side_b_t b_in;
    if (j == 0) begin : g_first
      assign b_in = b_nxt;
    end else begin : g_next
      assign b_in = b_line_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        b_line_r[j].valid <= 1'b0;
      end else if (en) begin
        b_line_r[j].valid <= b_in.valid;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        b_line_r[j].det_re  <= b_in.det_re;
        b_line_r[j].det_im  <= b_in.det_im;
        b_line_r[j].kund    <= b_in.kund;
        b_line_r[j].cund    <= b_in.cund;
        b_line_r[j].num_pos <= b_in.num_pos;
        b_line_r[j].cre_neg <= b_in.cre_neg;
        b_line_r[j].cim_neg <= b_in.cim_neg;
      end
    end
  end

  side_b_t b_end;
  assign b_end = b_line_r[sta_pkg::DIV_QW-1];

  // output register: saturate, zero undefined results and a non-positive k
  sta_pkg::out_t out_nxt;
  always_comb begin
    out_nxt.det_re           = b_end.det_re;
    out_nxt.det_im           = b_end.det_im;
    out_nxt.k_undefined      = b_end.kund;
    out_nxt.circle_undefined = b_end.cund;
    out_nxt.k_factor         = (b_end.kund || !b_end.num_pos) ? '0 : usat31(k_q, k_o);
    out_nxt.circle_center_re = b_end.cund ? '0 : ssat32(cr_q, cr_o, b_end.cre_neg);
    out_nxt.circle_center_im = b_end.cund ? '0 : ssat32(ci_q, ci_o, b_end.cim_neg);
    out_nxt.circle_radius    = b_end.cund ? '0 : usat31(rd_q, rd_o);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= b_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // k is forced to zero whenever it is undefined
  a_kund_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.k_undefined |-> out_item_r.k_factor == '0)
    else $error("k_factor nonzero while undefined");

  // circle results are zero whenever the denominator vanishes
  a_cund_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.circle_undefined |->
      out_item_r.circle_radius == '0 && out_item_r.circle_center_re == '0 &&
      out_item_r.circle_center_im == '0)
    else $error("circle result nonzero while undefined");

  // input holds only when a finished beat waits at the output
  a_hold_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without a held output beat");

  // a held pipeline does not move the last divider stage
  a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(b_end.valid))
    else $error("pipeline tail moved during hold");

endmodule

// ===== tb/twoport_stability_analysis_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twoport_stability_analysis_check: result predictor and comparator
// Watches both channels of the stability block, computes determinant,
// Rollett k and the stability circle for each accepted input beat, and
// compares every output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module twoport_stability_analysis_check (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  sta_pkg::in_t  in_item,
  input  logic          out_valid,
  input  logic          out_stall,
  input  sta_pkg::out_t out_item,
  output int            fail_count,
  output int            pending
);

  localparam longint POS_LIM = 64'sd2147483647;
  localparam longint NEG_LIM = 64'sd2147483648;

  sta_pkg::out_t stability_q[$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > POS_LIM) return POS_LIM;
    if (v < -NEG_LIM) return -NEG_LIM;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned quot_clip(longint unsigned n, longint unsigned d,
                                                int sh, longint unsigned lim);
    longint unsigned q, r;
    q = n / d;
    r = n % d;
    if (q > lim) return lim;
    for (int i = 0; i < sh; i++) begin
      q <<= 1;
      r <<= 1;
      if (r >= d) begin
        q++;
        r -= d;
      end
      if (q > lim) return lim;
    end
    return q;
  endfunction

  function automatic longint squot_clip(longint n, longint d, int sh);
    bit neg;
    longint unsigned q;
    neg = (n < 0) != (d < 0);
    q = quot_clip(n < 0 ? -n : n, d < 0 ? -d : d, sh, neg ? NEG_LIM : POS_LIM);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic sta_pkg::out_t stability_of(sta_pkg::in_t s);
    longint ar, ai, br, bi, cr, ci, dr, di;
    longint pr, pi, dtr, dti, wr, wi, n11, n22, nd, num, cden;
    longint spr, spi, sqr, sqi, qr, qi, numr, numi;
    longint unsigned normp, absp;
    sta_pkg::out_t o;
    ar = longint'(s.s11_re); ai = longint'(s.s11_im);
    br = longint'(s.s12_re); bi = longint'(s.s12_im);
    cr = longint'(s.s21_re); ci = longint'(s.s21_im);
    dr = longint'(s.s22_re); di = longint'(s.s22_im);
    pr = br * cr - bi * ci;
    pi = br * ci + bi * cr;
    dtr = ar * dr - ai * di - pr;
    dti = ar * di + ai * dr - pi;
    wr = floor_shr(dtr, sta_pkg::IN_FRAC_BITS);
    wi = floor_shr(dti, sta_pkg::IN_FRAC_BITS);
    n11 = ar * ar + ai * ai;
    n22 = dr * dr + di * di;
    nd = wr * wr + wi * wi;
    normp = longint'(pr * pr) + longint'(pi * pi);
    absp = root_floor(normp);
    spr = s.port_select ? dr : ar;
    spi = s.port_select ? di : ai;
    sqr = s.port_select ? ar : dr;
    sqi = s.port_select ? ai : di;
    cden = spr * spr + spi * spi - nd;
    o = '0;
    o.det_re = 32'(clip32(floor_shr(dtr,
                 2 * sta_pkg::IN_FRAC_BITS - sta_pkg::OUT_FRAC_BITS)));
    o.det_im = 32'(clip32(floor_shr(dti,
                 2 * sta_pkg::IN_FRAC_BITS - sta_pkg::OUT_FRAC_BITS)));
    o.k_undefined = normp == 0;
    o.circle_undefined = cden == 0;
    if (!o.k_undefined) begin
      num = (64'sd1 << (2 * sta_pkg::IN_FRAC_BITS)) - n11 - n22 + nd;
      if (num > 0)
        o.k_factor = 31'(quot_clip(num, 2 * absp, sta_pkg::OUT_FRAC_BITS, POS_LIM));
    end
    if (!o.circle_undefined) begin
      qr = wr * sqr + wi * sqi;
      qi = wi * sqr - wr * sqi;
      numr = spr * (64'sd1 << sta_pkg::IN_FRAC_BITS) - qr;
      numi = spi * (64'sd1 << sta_pkg::IN_FRAC_BITS) - qi;
      o.circle_center_re = 32'(squot_clip(numr, cden, sta_pkg::OUT_FRAC_BITS));
      o.circle_center_im = 32'(squot_clip(-numi, cden, sta_pkg::OUT_FRAC_BITS));
      o.circle_radius = 31'(quot_clip(absp, cden < 0 ? -cden : cden,
                                      sta_pkg::OUT_FRAC_BITS, POS_LIM));
    end
    return o;
  endfunction

  task automatic report(string fld, longint exp_v, longint got_v);
    $display("%0t: %s expected %0d got %0d", $time, fld, exp_v, got_v);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    sta_pkg::out_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) stability_q.push_back(stability_of(in_item));
      if (out_valid && !out_stall) begin
        if (stability_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_item);
          fail_count++;
        end else begin
          e = stability_q.pop_front();
          if (e.det_re !== out_item.det_re) report("det_re", e.det_re, out_item.det_re);
          if (e.det_im !== out_item.det_im) report("det_im", e.det_im, out_item.det_im);
          if (e.k_factor !== out_item.k_factor)
            report("k_factor", e.k_factor, out_item.k_factor);
          if (e.circle_center_re !== out_item.circle_center_re)
            report("circle_center_re", e.circle_center_re, out_item.circle_center_re);
          if (e.circle_center_im !== out_item.circle_center_im)
            report("circle_center_im", e.circle_center_im, out_item.circle_center_im);
          if (e.circle_radius !== out_item.circle_radius)
            report("circle_radius", e.circle_radius, out_item.circle_radius);
          if (e.k_undefined !== out_item.k_undefined)
            report("k_undefined", e.k_undefined, out_item.k_undefined);
          if (e.circle_undefined !== out_item.circle_undefined)
            report("circle_undefined", e.circle_undefined, out_item.circle_undefined);
        end
      end
    end
    pending <= stability_q.size();
  end

endmodule

// ===== tb/twoport_stability_analysis_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twoport_stability_analysis_test: top-level testbench
// Drives directed corner points and random S-parameter points in bursts
// with a stalling receiver; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module twoport_stability_analysis_test;

  localparam int LATENCY = 69;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  sta_pkg::in_t  in_item;
  logic          out_valid;
  logic          out_stall;
  sta_pkg::out_t out_item;
  int            fail_count;
  int            pending;
  int            stall_mode;

  twoport_stability_analysis dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  twoport_stability_analysis_check checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** twoport_stability_analysis: FAILED **");
    $finish;
  end

  // receiver stall pattern: phases of none, light, heavy and periodic stalls
  initial begin
    out_stall = 1'b0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ($time / 10) % 5 < 2;
      endcase
    end
  end

  function automatic logic [15:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'sd16384;
      4: return -16'sd16384;
      5, 6, 7: return 16'($signed($urandom_range(0, 32767)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_point(sta_pkg::in_t s);
    in_valid <= 1'b1;
    in_item  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  sta_pkg::in_t pt;
  int           burst;
  int           wait_cnt;

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zeros, extremes, k undefined, circle undefined, both ports
    for (int sel = 0; sel < 2; sel++) begin
      pt = '0; pt.port_select = 1'(sel);
      send_point(pt);
      pt = {{8{16'h8000}}, 1'b0}; pt.port_select = 1'(sel);
      send_point(pt);
      pt = {{8{16'h7fff}}, 1'b0}; pt.port_select = 1'(sel);
      send_point(pt);
      pt = '0; pt.s11_re = 16'sd8192; pt.s22_im = -16'sd8192; pt.port_select = 1'(sel);
      send_point(pt);
      pt = '0; pt.s12_re = 16'sd4096; pt.s21_re = 16'sd4096; pt.port_select = 1'(sel);
      send_point(pt);
      pt = '0; pt.s11_re = 16'sd4915; pt.s12_im = 16'sd1638; pt.s21_re = 16'sd32767;
      pt.s22_re = 16'sd8192; pt.port_select = 1'(sel);
      send_point(pt);
      pt = '0; pt.s11_re = 16'sd16384; pt.s22_re = 16'sd16384; pt.port_select = 1'(sel);
      send_point(pt);
      pt = {16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
            16'h7fff, 16'h7fff, 1'b0};
      pt.port_select = 1'(sel);
      send_point(pt);
      pt = {16'h0001, 16'hffff, 16'h0001, 16'h0001, 16'hffff, 16'h0001,
            16'h0001, 16'hffff, 1'b0};
      pt.port_select = 1'(sel);
      send_point(pt);
    end

    // random bursts; hold off once mid-run until the pipeline drains
    for (int n = 0; n < 650;) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < 650; b++, n++) begin
        pt.s11_re = pick_part(); pt.s11_im = pick_part();
        pt.s12_re = pick_part(); pt.s12_im = pick_part();
        pt.s21_re = pick_part(); pt.s21_im = pick_part();
        pt.s22_re = pick_part(); pt.s22_im = pick_part();
        pt.port_select = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 19) == 0) begin
          pt.s12_re = '0; pt.s12_im = '0;
        end
        send_point(pt);
      end
      if (n >= 300 && n < 300 + burst) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        idle_cycles($urandom_range(1, 20));
      end
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** twoport_stability_analysis: PASSED **");
    end else begin
      $display("** twoport_stability_analysis: FAILED **");
    end
    $finish;
  end

endmodule

// ===== twoport_stability_analysis.f =====
design/sta_pkg.sv
design/sta_front.sv
design/sta_isqrt.sv
design/sta_div.sv
design/twoport_stability_analysis.sv
tb/twoport_stability_analysis_check.sv
tb/twoport_stability_analysis_test.sv
